@@ rtl/core/dodv_pkg.sv @@
// ----------------------------------------------------------------------------
// dodv_pkg
// Shared types, constants and the control store of the delta-of-delta
// zigzag varint encoder.
// ----------------------------------------------------------------------------
package dodv_pkg;

  localparam int SAMPLE_BITS = 64;
  localparam int MAX_BYTES   = (SAMPLE_BITS + 6) / 7;
  localparam int CNT_W       = $clog2(MAX_BYTES);
  localparam int STEP_W      = 3;
  localparam int PHASE_W     = 2;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PH_STEADY = 2'd2;

  // coded value source
  localparam logic [1:0] SEL_VALUE = 2'd0;
  localparam logic [1:0] SEL_DIFF  = 2'd1;
  localparam logic [1:0] SEL_DOD   = 2'd2;

  // jump conditions
  localparam logic [2:0] JC_NEVER     = 3'd0;
  localparam logic [2:0] JC_ALWAYS    = 3'd1;
  localparam logic [2:0] JC_IN_ACC    = 3'd2;
  localparam logic [2:0] JC_PH_FIRST  = 3'd3;
  localparam logic [2:0] JC_PH_SECOND = 3'd4;
  localparam logic [2:0] JC_LAST_DONE = 3'd5;

  // program steps
  localparam logic [STEP_W-1:0] ST_WAIT   = 3'd0;
  localparam logic [STEP_W-1:0] ST_FIRST  = 3'd1;
  localparam logic [STEP_W-1:0] ST_DIFF   = 3'd2;
  localparam logic [STEP_W-1:0] ST_DOD    = 3'd3;
  localparam logic [STEP_W-1:0] ST_COMMIT = 3'd4;
  localparam logic [STEP_W-1:0] ST_EMIT   = 3'd5;

  typedef struct packed {
    logic              wait_in;   // ready for an item, load sample
    logic              ld_coded;
    logic [1:0]        coded_sel;
    logic              ld_delta;
    logic              commit;    // update history, zigzag the coded value
    logic              emit;      // present the current byte
    logic [2:0]        cond;
    logic              hold;      // stay on this step when cond is false
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic in_acc;
    logic ph_first;
    logic ph_second;
    logic last_done;
  } seq_status_t;

  function automatic ctl_word_t ctl_rom(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '{wait_in: 1'b0, ld_coded: 1'b0, coded_sel: SEL_VALUE, ld_delta: 1'b0,
          commit: 1'b0, emit: 1'b0, cond: JC_ALWAYS, hold: 1'b0, target: ST_WAIT};
    case (step)
      ST_WAIT: begin
        w.wait_in = 1'b1;
        w.cond    = JC_IN_ACC;
        w.hold    = 1'b1;
        w.target  = ST_FIRST;
      end
      ST_FIRST: begin
        w.ld_coded  = 1'b1;
        w.coded_sel = SEL_VALUE;
        w.cond      = JC_PH_FIRST;
        w.target    = ST_COMMIT;
      end
      ST_DIFF: begin
        w.ld_coded  = 1'b1;
        w.coded_sel = SEL_DIFF;
        w.ld_delta  = 1'b1;
        w.cond      = JC_PH_SECOND;
        w.target    = ST_COMMIT;
      end
      ST_DOD: begin
        w.ld_coded  = 1'b1;
        w.coded_sel = SEL_DOD;
        w.cond      = JC_NEVER;
      end
      ST_COMMIT: begin
        w.commit = 1'b1;
        w.cond   = JC_NEVER;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = JC_LAST_DONE;
        w.hold   = 1'b1;
        w.target = ST_WAIT;
      end
      default: begin
        w.cond   = JC_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/dodv_seq.sv @@
// ----------------------------------------------------------------------------
// dodv_seq
// Step counter and control store: one control word per step, with
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module dodv_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dodv_pkg::seq_status_t status,
  output dodv_pkg::ctl_word_t   ctl
);
  import dodv_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              taken;

  assign ctl = ctl_rom(step_r);

  always_comb begin
    case (ctl.cond)
      JC_NEVER:     taken = 1'b0;
      JC_ALWAYS:    taken = 1'b1;
      JC_IN_ACC:    taken = status.in_acc;
      JC_PH_FIRST:  taken = status.ph_first;
      JC_PH_SECOND: taken = status.ph_second;
      JC_LAST_DONE: taken = status.last_done;
      default:      taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      step_nxt = ctl.target;
    end else if (ctl.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ rtl/core/delta_of_delta_varint_encoder.sv @@
// ----------------------------------------------------------------------------
// delta_of_delta_varint_encoder
// Codes each sample as itself, its delta, or its delta of delta, zigzag
// maps the result and sends it out as a little-endian base-128 varint.
//
//   channel | ports                                | direction
//   --------+--------------------------------------+----------
//   input   | in_valid in_ready in_sample          | in
//   result  | out_valid out_ready out_code_byte     | out
//           | out_last_byte                        |
//
// one item takes 3, 4 or 5 control steps (first, second or steady sample,
// the accepting step included) plus one cycle per varint byte (1 to 10)
// while the result is not stalled, as the microcode sequence sets it
// reset returns the step counter to the wait step and the phase to first
// a stalled result byte holds the byte step; no item is taken meanwhile
// ----------------------------------------------------------------------------
module delta_of_delta_varint_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_code_byte,
  output logic        out_last_byte
);
  import dodv_pkg::*;

  ctl_word_t   ctl;
  seq_status_t status;

  logic [SAMPLE_BITS-1:0] value_r;
  logic [SAMPLE_BITS-1:0] prev_sample_r;
  logic [SAMPLE_BITS-1:0] prev_delta_r;
  logic [SAMPLE_BITS-1:0] delta_r;
  logic [SAMPLE_BITS-1:0] coded_r;
  logic [SAMPLE_BITS-1:0] zz_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [PHASE_W-1:0]     phase_r;

  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS-1:0] coded_nxt;
  logic [SAMPLE_BITS-1:0] zigzag;
  logic                   in_acc;
  logic                   out_acc;
  logic                   is_last;

  dodv_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  assign in_ready  = ctl.wait_in;
  assign out_valid = ctl.emit;
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;

  assign diff   = value_r - prev_sample_r;
  assign zigzag = {coded_r[SAMPLE_BITS-2:0], 1'b0} ^ {SAMPLE_BITS{coded_r[SAMPLE_BITS-1]}};

  // last group when nothing above bit 6 remains, or the byte cap is reached
  assign is_last       = (zz_r[SAMPLE_BITS-1:7] == '0) || (cnt_r == CNT_W'(MAX_BYTES - 1));
  assign out_code_byte = is_last ? zz_r[7:0] : {1'b1, zz_r[6:0]};
  assign out_last_byte = is_last;

  assign status = '{in_acc:    in_acc,
                    ph_first:  (phase_r == PH_FIRST),
                    ph_second: (phase_r == PH_SECOND),
                    last_done: (out_acc & is_last)};

  always_comb begin
    case (ctl.coded_sel)
      SEL_VALUE: coded_nxt = value_r;
      SEL_DIFF:  coded_nxt = diff;
      SEL_DOD:   coded_nxt = delta_r - prev_delta_r;
      default:   coded_nxt = value_r;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r <= in_sample[SAMPLE_BITS-1:0];
    end
    if (ctl.ld_coded) begin
      coded_r <= coded_nxt;
    end
    if (ctl.ld_delta) begin
      delta_r <= diff;
    end
    if (ctl.commit) begin
      zz_r <= zigzag;
    end else if (out_acc && !is_last) begin
      zz_r <= zz_r >> 7;
    end
  end

  // history and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      prev_delta_r  <= '0;
      phase_r       <= PH_FIRST;
      cnt_r         <= '0;
    end else begin
      if (ctl.commit) begin
        prev_sample_r <= value_r;
        if (phase_r != PH_FIRST) begin
          prev_delta_r <= delta_r;
        end
        phase_r <= (phase_r == PH_FIRST) ? PH_SECOND : PH_STEADY;
        cnt_r   <= '0;
      end else if (out_acc && !is_last) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

endmodule
